FILE: rtl/core/tfrb_pkg.sv
// shared types, codes and widths for the timestamped frame ring buffer
// no dependencies

package tfrb_pkg;

    localparam int CAP_LOG2_DEF   = 10;
    localparam int FRAME_BITS_DEF = 32;

    localparam int TIME_W   = 64;
    localparam int NFR_W    = 11;
    localparam int BEAT_W   = 10;
    localparam int FIN_W    = 32;
    localparam int FOUT_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_STORE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FETCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EARLY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LATE     = 2'd3;

    typedef logic [TIME_W-1:0] t_time;

    typedef struct packed {
        logic too_long;
        logic clr;
        logic adv;
        logic gap_f;
        logic early;
    } t_dec;

    function automatic logic lt_s(input t_time a, input t_time b);
        lt_s = $signed(a) < $signed(b);
    endfunction

endpackage

FILE: rtl/core/tfrb_dec.sv
// window decision logic: compares a request block against the current window
// depends on tfrb_pkg

module tfrb_dec #(
    parameter int CAP_LOG2 = tfrb_pkg::CAP_LOG2_DEF
) (
    input  tfrb_pkg::t_time          i_bstart,
    input  logic [tfrb_pkg::NFR_W-1:0] i_nfr,
    input  tfrb_pkg::t_time          i_ws,
    input  tfrb_pkg::t_time          i_we,
    output tfrb_pkg::t_dec           o_dec,
    output tfrb_pkg::t_time          o_bend,
    output logic [CAP_LOG2:0]        o_gap
);

    localparam logic [63:0]       CAP64   = 64'(1) << CAP_LOG2;
    localparam logic [CAP_LOG2:0] CAP_VAL = (CAP_LOG2 + 1)'(1) << CAP_LOG2;

    tfrb_pkg::t_time bend;
    tfrb_pkg::t_time diff;

    assign bend = i_bstart + 64'(i_nfr);
    assign diff = i_bstart - i_we;

    always_comb begin
        o_dec.too_long = 64'(i_nfr) > CAP64;
        o_dec.clr      = !tfrb_pkg::lt_s(i_bstart, i_we + CAP64);
        o_dec.adv      = tfrb_pkg::lt_s(i_we, bend);
        o_dec.gap_f    = tfrb_pkg::lt_s(i_we, i_bstart);
        o_dec.early    = tfrb_pkg::lt_s(i_bstart, i_ws);
    end

    assign o_bend = bend;
    assign o_gap  = (diff > CAP64) ? CAP_VAL : diff[CAP_LOG2:0];

endmodule

FILE: rtl/core/timestamped_frame_ring_buffer_unit.sv
// timestamped frame ring buffer: frame ring memory, window state and sequencer
// depends on tfrb_pkg and tfrb_dec
//
// channel | dir | tdata (low bit up)                              | tuser    | tlast
// s       | in  | block_start, block_frames, beat_index, frame_in | req_type | -
// m       | out | frame_out, frame_offset                         | status   | block_last
//
// store or fetch beat: accept, decide, then memory access; a rejected store or
// unused request skips the memory access; beat 0 of a store adds window steps and a gap fill
// clear request: a write pass over every ring slot (one write port); a clearing store too
// after reset a pass zeroes the ring before the first transaction
// a stalled output holds its result; the next transaction is taken meanwhile

module timestamped_frame_ring_buffer_unit #(
    parameter int CAP_LOG2   = tfrb_pkg::CAP_LOG2_DEF,
    parameter int FRAME_BITS = tfrb_pkg::FRAME_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [119:0] i_s_tdata,  // block_start, block_frames, beat_index, frame_in, zero pad
    input  logic [1:0]   i_s_tuser,  // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,  // frame_out, frame_offset
    output logic [1:0]   o_m_tuser,  // status
    output logic         o_m_tlast   // block_last
);

    localparam int          L     = CAP_LOG2;
    localparam int          KEEP  = (FRAME_BITS < tfrb_pkg::FIN_W) ? FRAME_BITS : tfrb_pkg::FIN_W;
    localparam logic [63:0] CAP64 = 64'(1) << CAP_LOG2;

    localparam logic [3:0] S_BOOT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_WIN   = 4'd4;
    localparam logic [3:0] S_GAP   = 4'd5;
    localparam logic [3:0] S_ADV   = 4'd6;
    localparam logic [3:0] S_SLIDE = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [FRAME_BITS-1:0] mem [(1 << CAP_LOG2)];

    logic [3:0]  r_state, n_state;
    logic [L:0]  r_cnt, n_cnt;
    tfrb_pkg::t_time r_ws, n_ws;
    tfrb_pkg::t_time r_we, n_we;
    tfrb_pkg::t_time r_ns, n_ns;
    logic [L-1:0] r_slot, n_slot;
    logic r_empty, n_empty;
    logic r_slide, n_slide;

    logic [tfrb_pkg::REQ_W-1:0]  r_req;
    tfrb_pkg::t_time             r_bstart;
    logic [tfrb_pkg::NFR_W-1:0]  r_nfr;
    logic [tfrb_pkg::BEAT_W-1:0] r_beat;
    logic [tfrb_pkg::FIN_W-1:0]  r_fin;

    tfrb_pkg::t_dec  dec, r_dec;
    tfrb_pkg::t_time bend, r_bend;
    logic [L:0]      gap, r_gap;

    logic [FRAME_BITS-1:0] r_rdata;

    logic                           r_out_valid;
    logic [tfrb_pkg::STATUS_W-1:0]  r_status, e_status;
    logic [tfrb_pkg::FOUT_W-1:0]    r_fout, e_fout;
    tfrb_pkg::t_time                r_offs, e_offs;
    logic                           r_last, e_last;
    logic                           emit;

    logic                  accept, out_free, beat_in, beat_last, sweep_end;
    logic [L-1:0]          slot_addr, gap_base;
    logic                  mem_we, mem_re;
    logic [L-1:0]          mem_waddr;
    logic [FRAME_BITS-1:0] mem_wdata;

    tfrb_dec #(
        .CAP_LOG2(CAP_LOG2)
    ) u_dec (
        .i_bstart(r_bstart),
        .i_nfr   (r_nfr),
        .i_ws    (r_ws),
        .i_we    (r_we),
        .o_dec   (dec),
        .o_bend  (bend),
        .o_gap   (gap)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign beat_in    = {1'b0, r_beat} < r_nfr;
    assign beat_last  = ({1'b0, r_beat} + 11'd1) >= r_nfr;
    assign sweep_end  = &r_cnt[L-1:0];
    assign slot_addr  = r_slot + (r_bstart[L-1:0] + L'(r_beat) - r_ws[L-1:0]);
    assign gap_base   = r_slot + (r_we[L-1:0] - r_ws[L-1:0]);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ws      = r_ws;
        n_we      = r_we;
        n_ns      = r_ns;
        n_slot    = r_slot;
        n_empty   = r_empty;
        n_slide   = r_slide;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = slot_addr;
        mem_wdata = '0;
        emit      = 1'b0;
        e_status  = tfrb_pkg::ST_OK;
        e_fout    = '0;
        e_offs    = '0;
        e_last    = 1'b0;
        unique case (r_state)
            S_BOOT, S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[L-1:0];
                n_cnt     = r_cnt + 1'b1;
                if (sweep_end) begin
                    n_cnt   = '0;
                    n_ws    = '0;
                    n_we    = '0;
                    n_slot  = '0;
                    n_empty = 1'b1;
                    if (r_state == S_BOOT) begin
                        n_state = S_IDLE;
                    end else if (r_req == tfrb_pkg::REQ_STORE) begin
                        n_state = S_WIN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (r_req)
                    tfrb_pkg::REQ_STORE: begin
                        if (dec.too_long) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_status = tfrb_pkg::ST_TOO_LONG;
                                e_last   = beat_last;
                                n_state  = S_IDLE;
                            end
                        end else if (r_beat == '0) begin
                            n_cnt   = '0;
                            n_state = dec.clr ? S_CLR : S_WIN;
                        end else begin
                            n_state = S_WR;
                        end
                    end
                    tfrb_pkg::REQ_FETCH: begin
                        mem_re  = 1'b1;
                        n_state = S_RD;
                    end
                    tfrb_pkg::REQ_CLEAR: begin
                        n_cnt   = '0;
                        n_state = S_CLR;
                    end
                    default: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_WIN: begin
                priority if (r_empty) begin
                    n_ws    = r_bstart;
                    n_we    = r_bend;
                    n_slot  = '0;
                    n_empty = 1'b0;
                    n_state = S_WR;
                end else if (r_dec.adv) begin
                    n_cnt   = '0;
                    n_state = r_dec.gap_f ? S_GAP : S_ADV;
                end else begin
                    n_state = S_WR;
                end
            end
            S_GAP: begin
                mem_we    = 1'b1;
                mem_waddr = gap_base + r_cnt[L-1:0];
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == r_gap - 1'b1) begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                n_we    = r_bend;
                n_ns    = r_bend - CAP64;
                n_slide = tfrb_pkg::lt_s(r_ws, r_bend - CAP64);
                n_state = S_SLIDE;
            end
            S_SLIDE: begin
                if (r_slide) begin
                    n_slot = r_slot + (r_ns[L-1:0] - r_ws[L-1:0]);
                    n_ws   = r_ns;
                end
                n_state = S_WR;
            end
            S_WR: begin
                if (out_free) begin
                    mem_we    = beat_in;
                    mem_wdata = FRAME_BITS'(r_fin[KEEP-1:0]);
                    emit      = 1'b1;
                    e_last    = beat_last;
                    n_state   = S_IDLE;
                end
            end
            S_RD: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_last = beat_last;
                    priority if (r_dec.early) begin
                        e_status = tfrb_pkg::ST_EARLY;
                        e_offs   = r_bstart - r_ws;
                    end else if (r_dec.adv) begin
                        e_status = tfrb_pkg::ST_LATE;
                        e_offs   = r_bend - r_we;
                    end else begin
                        e_offs = r_we - r_bend;
                        if (beat_in) begin
                            e_fout = 32'(r_rdata[KEEP-1:0]);
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_cnt       <= '0;
            r_ws        <= '0;
            r_we        <= '0;
            r_slot      <= '0;
            r_empty     <= 1'b1;
            r_slide     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ws    <= n_ws;
            r_we    <= n_we;
            r_slot  <= n_slot;
            r_empty <= n_empty;
            r_slide <= n_slide;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ns <= n_ns;
        if (accept) begin
            r_req    <= i_s_tuser;
            r_bstart <= i_s_tdata[63:0];
            r_nfr    <= i_s_tdata[74:64];
            r_beat   <= i_s_tdata[84:75];
            r_fin    <= i_s_tdata[116:85];
        end
        if (r_state == S_DEC) begin
            r_dec  <= dec;
            r_bend <= bend;
            r_gap  <= gap;
        end
        if (emit) begin
            r_status <= e_status;
            r_fout   <= e_fout;
            r_offs   <= e_offs;
            r_last   <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[slot_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_offs, r_fout};
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

    a_accept_to_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DEC))
        else $error("accepted transaction not decoded");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !mem_we)
        else $error("ring written while idle");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLR || r_state == S_BOOT) && sweep_end) |=> (r_empty && r_we == '0))
        else $error("clear pass did not reset the window");

    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAP) |-> (r_cnt < r_gap))
        else $error("gap fill overran");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result overwrote a pending transaction");

endmodule
